@@ rtl/core/can_id_statistics_table_core_macros.svh @@
// assertion macros for the can id statistics table core
// used by rtl modules that check their own control logic, clocked on clk_i, reset rst_ni
`ifndef CAN_ID_STATISTICS_TABLE_CORE_MACROS_SVH
`define CAN_ID_STATISTICS_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CIDST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CIDST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CIDST_ASSERT(lbl, prop, msg)
`define CIDST_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/core/cidst_pkg.sv @@
// shared types and constants for the can id statistics table core
// no dependencies
`default_nettype none

package cidst_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [28:0] frame_id;
    logic [31:0] frame_flags;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [31:0] frame_time;
    logic [5:0]  row;
  } in_t;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic        was_hit;
    logic        table_full;
    logic        entry_valid;
    logic [31:0] msg_count;
    logic [31:0] interval;
    logic [28:0] out_id;
    logic [31:0] out_flags;
    logic [3:0]  out_length;
    logic [63:0] out_data;
    logic [6:0]  rows_used;
  } out_t;

  // one table row as held by a cell
  typedef struct packed {
    logic [28:0] id;
    logic [31:0] flags;
    logic [31:0] stamp;
    logic [31:0] interval;
    logic [31:0] count;
    logic [3:0]  length;
    logic [63:0] data;
  } entry_t;

  // status from the head update logic
  typedef struct packed {
    logic match;
    logic append;
  } upd_t;

endpackage

`default_nettype wire

@@ rtl/core/cidst_cell.sv @@
// one storage cell of the rotating table chain
// depends on cidst_pkg for the entry type
`default_nettype none

module cidst_cell (
  input  wire                  clk_i,
  input  wire                  shift_i,
  input  cidst_pkg::entry_t    entry_i,
  output cidst_pkg::entry_t    entry_o
);

  cidst_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ rtl/core/cidst_update.sv @@
// head-of-chain compare and update logic: matches the leaving row against the
// frame key and builds the row that re-enters at the tail; depends on cidst_pkg
`default_nettype none

module cidst_update (
  input  wire                            active_i,
  input  wire                            found_i,
  input  cidst_pkg::in_t                 req_i,
  input  wire [cidst_pkg::IDX_W-1:0]     step_i,
  input  wire [cidst_pkg::USED_W-1:0]    used_i,
  input  cidst_pkg::entry_t              head_i,
  output cidst_pkg::entry_t              wrap_o,
  output cidst_pkg::upd_t                upd_o
);

  logic is_frame;
  logic in_use;
  logic key_eq;

  assign is_frame = active_i && (req_i.cmd == cidst_pkg::CMD_FRAME) && !found_i;
  assign in_use   = cidst_pkg::USED_W'(step_i) < used_i;
  assign key_eq   = (head_i.id == req_i.frame_id) && (head_i.flags == req_i.frame_flags);

  assign upd_o.match  = is_frame && in_use && key_eq;
  // first free row comes after every used row, so no match can be pending
  assign upd_o.append = is_frame && (cidst_pkg::USED_W'(step_i) == used_i);

  always_comb begin
    wrap_o = head_i;
    if (upd_o.match) begin
      wrap_o.data     = req_i.frame_data;
      wrap_o.length   = req_i.frame_length;
      wrap_o.count    = (head_i.count == '1) ? head_i.count : head_i.count + 32'd1;
      wrap_o.interval = req_i.frame_time - head_i.stamp;
      wrap_o.stamp    = req_i.frame_time;
    end else if (upd_o.append) begin
      wrap_o.id       = req_i.frame_id;
      wrap_o.flags    = req_i.frame_flags;
      wrap_o.data     = req_i.frame_data;
      wrap_o.length   = req_i.frame_length;
      wrap_o.count    = 32'd1;
      wrap_o.interval = 32'd0;
      wrap_o.stamp    = req_i.frame_time;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/can_id_statistics_table_core.sv @@
// can id statistics table: rows live in a ring of TABLE_ENTRIES cells that rotates once per frame
// or read command, which gives its result once one full turn of the cell ring is done; clear
// and no-op commands do not turn the ring and give their result the next cycle
// one command at a time: the next transfer is taken the cycle after the result is taken, so
// no new command is taken while a scan is running or an earlier result is still pending
// reset empties the table (row count zero); stored rows keep no reset value
`default_nettype none
`include "can_id_statistics_table_core_macros.svh"

module can_id_statistics_table_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  cidst_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output cidst_pkg::out_t  out_data_o
);

  localparam int unsigned N = cidst_pkg::TABLE_ENTRIES;

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e                        state_q, state_d;
  cidst_pkg::in_t                req_q, req_d;
  cidst_pkg::out_t               res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  logic [cidst_pkg::IDX_W-1:0]   step_q, step_d;
  logic [cidst_pkg::USED_W-1:0]  used_q, used_d;
  logic                          found_q, found_d;

  cidst_pkg::entry_t chain [N];
  cidst_pkg::entry_t wrap;
  cidst_pkg::upd_t   upd;

  logic shift;
  logic accept;
  logic last;
  logic cap_read;

  assign shift      = (state_q == ST_SCAN);
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = step_q == cidst_pkg::IDX_W'(N - 1);

  // row k moves to cell k-1 each scan cycle; cell 0 re-enters at the tail through the update
  for (genvar k = 0; k < N; k++) begin : g_cell
    cidst_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i ((k == N - 1) ? wrap : chain[(k + 1) % N]),
      .entry_o (chain[k])
    );
  end

  cidst_update u_update (
    .active_i (shift),
    .found_i  (found_q),
    .req_i    (req_q),
    .step_i   (step_q),
    .used_i   (used_q),
    .head_i   (chain[0]),
    .wrap_o   (wrap),
    .upd_o    (upd)
  );

  assign cap_read = shift && (req_q.cmd == cidst_pkg::CMD_READ)
                    && (32'(req_q.row) == 32'(step_q))
                    && (32'(req_q.row) < 32'(used_q));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    step_d      = step_q;
    used_d      = used_q;
    found_d     = found_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = in_data_i;
          res_d = '0;
          if (in_data_i.cmd == cidst_pkg::CMD_READ) begin
            res_d.entry_index = in_data_i.row;
          end
          if (in_data_i.cmd == cidst_pkg::CMD_FRAME || in_data_i.cmd == cidst_pkg::CMD_READ) begin
            state_d = ST_SCAN;
            step_d  = '0;
            found_d = 1'b0;
          end else begin
            if (in_data_i.cmd == cidst_pkg::CMD_CLEAR) begin
              used_d = '0;
            end
            res_d.rows_used = 7'(used_d);
            out_valid_d     = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        step_d = last ? '0 : cidst_pkg::IDX_W'(step_q + 1'b1);
        if (upd.append) begin
          used_d = cidst_pkg::USED_W'(used_q + 1'b1);
        end
        if (upd.match || upd.append) begin
          found_d           = 1'b1;
          res_d.entry_index = 6'(step_q);
          res_d.was_hit     = upd.match;
          res_d.entry_valid = 1'b1;
          res_d.msg_count   = wrap.count;
          res_d.interval    = wrap.interval;
          res_d.out_id      = wrap.id;
          res_d.out_flags   = wrap.flags;
          res_d.out_length  = wrap.length;
          res_d.out_data    = wrap.data;
        end
        if (cap_read) begin
          res_d.entry_valid = 1'b1;
          res_d.msg_count   = chain[0].count;
          res_d.interval    = chain[0].interval;
          res_d.out_id      = chain[0].id;
          res_d.out_flags   = chain[0].flags;
          res_d.out_length  = chain[0].length;
          res_d.out_data    = chain[0].data;
        end
        if (last) begin
          state_d          = ST_IDLE;
          out_valid_d      = 1'b1;
          res_d.rows_used  = 7'(used_d);
          // new key with no free row is dropped
          res_d.table_full = (req_q.cmd == cidst_pkg::CMD_FRAME) && !found_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      used_q      <= '0;
      found_q     <= 1'b0;
      req_q       <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      used_q      <= used_d;
      found_q     <= found_d;
      req_q       <= req_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `CIDST_ASSERT(a_used_bound, 32'(used_q) <= N, "row count above table size")
  `CIDST_ASSERT(a_one_update, !(upd.match && upd.append), "hit and append in one cycle")
  `CIDST_ASSERT_NEXT(a_scan_done, shift && last, out_valid_q && !shift, "scan end gave no result")
  `CIDST_ASSERT(a_full_only_when_full, !res_q.table_full || 32'(used_q) == N, "drop with free rows")
  `CIDST_ASSERT(a_hit_is_valid, !(out_valid_q && res_q.was_hit) || res_q.entry_valid, "hit without entry")

endmodule

`default_nettype wire
